FILE: src/mdpr_pkg.sv
// Shared types and constants for the minimum dot product rearrangement unit.
package mdpr_pkg;

  localparam int DATA_W      = 16;
  localparam int SUM_W       = 38;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int MAX_LEN_DEF = 64;

  // Controller phases: load pairs into the chain, then walk it to sum.
  typedef enum logic {
    ST_LOAD,
    ST_SUM
  } state_t;

  // What one cell shows its neighbours.
  typedef struct packed {
    logic              valid;
    logic              a_gt;   // held first-list value sorts after the new one
    logic              b_lt;   // held second-list value sorts after the new one
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } link_t;

  // Chain-wide commands from the controller.
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctl_t;

endpackage

FILE: src/min_dot_product_rearrange_unit.sv
// Minimum dot product unit: while loading, one (a_value, b_value) word is taken every cycle and
// dropped straight into its sorted place in a chain of MAX_LEN cells (first list ascending,
// second list descending); pairs beyond MAX_LEN are discarded, the final pair included. The word
// flagged last_pair starts the sum: the chain then drains one cell per cycle into a single
// 16x16 multiplier and a 38-bit accumulator; no input is taken during the sum phase. If the
// previous result is still waiting in the output register, the sum phase holds on until that
// word is taken. The result sits in an output register, so loading of the next lists may
// start while it waits to be taken.
module min_dot_product_rearrange_unit #(
  parameter int MAX_LEN = mdpr_pkg::MAX_LEN_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [mdpr_pkg::DATA_W-1:0] a_value,
  input  logic [mdpr_pkg::DATA_W-1:0] b_value,
  input  logic                        last_pair,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mdpr_pkg::SUM_W-1:0]  min_sum
);

  mdpr_pkg::state_t             state;
  mdpr_pkg::state_t             state_next;
  mdpr_pkg::cell_ctl_t          ctl;
  mdpr_pkg::link_t              links [MAX_LEN];
  mdpr_pkg::link_t              head_link;
  mdpr_pkg::link_t              tail_link;
  logic [MAX_LEN-1:0]           cell_valid;
  logic                         full;
  logic                         accept;
  logic                         sum_done;
  logic                         out_load;
  logic [mdpr_pkg::PROD_W-1:0]  prod;
  logic                         prod_vld;
  logic [mdpr_pkg::SUM_W-1:0]   acc;

  // The front cell sees a virtual full neighbour that never moves; the back cell drains empties
  assign head_link = '{valid: 1'b1, a_gt: 1'b0, b_lt: 1'b0, a: '0, b: '0};
  assign tail_link = '{valid: 1'b0, a_gt: 1'b1, b_lt: 1'b1, a: '0, b: '0};

  // Build the sorting chain
  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    mdpr_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctl   (ctl),
      .a_new (a_value),
      .b_new (b_value),
      .prev  ((i == 0) ? head_link : links[(i == 0) ? 0 : i - 1]),
      .next  ((i == MAX_LEN - 1) ? tail_link : links[(i == MAX_LEN - 1) ? i : i + 1]),
      .self  (links[i])
    );
    assign cell_valid[i] = links[i].valid;
  end

  assign full     = cell_valid[MAX_LEN-1];
  assign accept   = in_valid && in_ready;
  assign sum_done = !cell_valid[0] && !prod_vld;

  // Sequence loading and summing
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ctl        = '{insert: 1'b0, shift: 1'b0};
    out_load   = 1'b0;
    case (state)
      mdpr_pkg::ST_LOAD: begin
        in_ready   = 1'b1;
        ctl.insert = in_valid && !full;
        if (in_valid && last_pair) begin
          state_next = mdpr_pkg::ST_SUM;
        end
      end
      mdpr_pkg::ST_SUM: begin
        ctl.shift = 1'b1;
        if (sum_done && (!out_valid || out_ready)) begin
          out_load   = 1'b1;
          state_next = mdpr_pkg::ST_LOAD;
        end
      end
      default: begin
        state_next = mdpr_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mdpr_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Multiply the front pair as it leaves the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= ctl.shift && links[0].valid;
    end
  end

  always_ff @(posedge clk) begin
    prod <= links[0].a * links[0].b;
  end

  // Accumulate, clearing as the sum phase opens; wraps modulo the result width
  always_ff @(posedge clk) begin
    if (accept && last_pair) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + mdpr_pkg::SUM_W'(prod);
    end
  end

  // Hold the result word until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      min_sum <= acc;
    end
  end

`ifndef SYNTHESIS
  logic [MAX_LEN:0] vld_plus;
  assign vld_plus = {1'b0, cell_valid} + {{MAX_LEN{1'b0}}, 1'b1};

  // Occupied cells always form an unbroken run from the front
  assert property (@(posedge clk) disable iff (rst) $onehot(vld_plus))
    else $error("cell chain has a gap");

  // A final pair opens the sum phase with a cleared accumulator
  assert property (@(posedge clk) disable iff (rst)
    accept && last_pair |=> (state == mdpr_pkg::ST_SUM) && (acc == '0))
    else $error("sum phase not entered cleanly");

  // Products only flow while summing
  assert property (@(posedge clk) disable iff (rst)
    prod_vld |-> (state == mdpr_pkg::ST_SUM))
    else $error("product outside sum phase");

  // A new result appears only at the close of a sum phase
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == mdpr_pkg::ST_SUM) && (state == mdpr_pkg::ST_LOAD))
    else $error("result raised outside sum close");
`endif

endmodule

FILE: src/mdpr_cell.sv
// One sorting cell: holds one first-list value (ascending) and one second-list value (descending).
module mdpr_cell (
  input  logic                               clk,
  input  logic                               rst,
  input  mdpr_pkg::cell_ctl_t                ctl,
  input  logic [mdpr_pkg::DATA_W-1:0]        a_new,
  input  logic [mdpr_pkg::DATA_W-1:0]        b_new,
  input  mdpr_pkg::link_t                    prev,
  input  mdpr_pkg::link_t                    next,
  output mdpr_pkg::link_t                    self
);

  logic                        valid;
  logic [mdpr_pkg::DATA_W-1:0] a;
  logic [mdpr_pkg::DATA_W-1:0] b;
  logic                        a_gt;
  logic                        b_lt;

  // Compare the incoming pair against the held pair; an empty cell always yields
  assign a_gt = !valid || (a > a_new);
  assign b_lt = !valid || (b < b_new);

  assign self.valid = valid;
  assign self.a_gt  = a_gt;
  assign self.b_lt  = b_lt;
  assign self.a     = a;
  assign self.b     = b;

  // Hold the valid flag: fill from the front on insert, drain toward the front on shift
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.shift) begin
      valid <= next.valid;
    end else if (ctl.insert) begin
      valid <= valid | prev.valid;
    end
  end

  // Advance the values: take the new word at the insertion point, otherwise shuffle up
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      a <= next.a;
      b <= next.b;
    end else if (ctl.insert) begin
      if (a_gt && !prev.a_gt) begin
        a <= a_new;
      end else if (a_gt) begin
        a <= prev.a;
      end
      if (b_lt && !prev.b_lt) begin
        b <= b_new;
      end else if (b_lt) begin
        b <= prev.b;
      end
    end
  end

endmodule

FILE: sim/min_dot_product_rearrange_unit_tb.sv
// Self-checking testbench for the minimum dot product rearrangement unit.
module min_dot_product_rearrange_unit_tb;

  localparam int STORE_DEPTH = mdpr_pkg::MAX_LEN_DEF;
  localparam int RANDOM_PAIRS = 1200;

  typedef logic [mdpr_pkg::DATA_W-1:0] word_t;
  typedef logic [mdpr_pkg::SUM_W-1:0] sum_t;
  typedef word_t word_q_t[$];

  // One directed word; known rows carry a sum typed in by hand.
  typedef struct packed {
    word_t a;
    word_t b;
    logic  fin;
    logic  known;
    sum_t  sum;
  } pair_row_t;

  localparam pair_row_t DIRECTED_ROWS [15] = '{
    '{16'd0,      16'd0,      1'b1, 1'b1, 38'd0},
    '{16'hFFFF,   16'hFFFF,   1'b1, 1'b1, 38'd4294836225},
    '{16'hFFFF,   16'd0,      1'b0, 1'b0, 38'd0},
    '{16'd0,      16'hFFFF,   1'b1, 1'b1, 38'd0},
    '{16'hFFFF,   16'hFFFF,   1'b0, 1'b0, 38'd0},
    '{16'hFFFF,   16'hFFFF,   1'b1, 1'b1, 38'd8589672450},
    '{16'd1,      16'd2,      1'b0, 1'b0, 38'd0},
    '{16'd3,      16'd4,      1'b0, 1'b0, 38'd0},
    '{16'd5,      16'd6,      1'b1, 1'b0, 38'd0},
    '{16'd7,      16'd7,      1'b0, 1'b0, 38'd0},
    '{16'd7,      16'd3,      1'b0, 1'b0, 38'd0},
    '{16'd2,      16'd7,      1'b1, 1'b0, 38'd0},
    '{16'hAAAA,   16'h5555,   1'b0, 1'b0, 38'd0},
    '{16'h5555,   16'hAAAA,   1'b1, 1'b0, 38'd0},
    '{16'hFFFF,   16'd1,      1'b1, 1'b0, 38'd0}
  };

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_ready;
  word_t a_value = '0;
  word_t b_value = '0;
  logic  last_pair = 1'b0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  sum_t  min_sum;

  // Predictor state: pairs held for the list being loaded, sums still owed.
  word_q_t held_a;
  word_q_t held_b;
  sum_t    pending_sums[$];

  int errors = 0;
  int pairs_sent = 0;
  int lists_sent = 0;
  int overlong_lists = 0;
  int sums_taken = 0;
  bit no_idle = 1'b0;

  min_dot_product_rearrange_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .a_value   (a_value),
    .b_value   (b_value),
    .last_pair (last_pair),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .min_sum   (min_sum)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic flag_mismatch(input string msg);
    errors++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  function automatic word_q_t ascending(input word_q_t v);
    word_t key;
    int    j;
    for (int i = 1; i < v.size(); i++) begin
      key = v[i];
      j = i;
      while (j > 0 && v[j-1] > key) begin
        v[j] = v[j-1];
        j--;
      end
      v[j] = key;
    end
    return v;
  endfunction

  // Smallest ascending first list against descending second list, wrapped to the sum width.
  function automatic sum_t min_pairing_sum(input word_q_t av, input word_q_t bv);
    word_q_t sa;
    word_q_t sb;
    sum_t    acc;
    int      n;
    sa = ascending(av);
    sb = ascending(bv);
    n = sa.size();
    acc = '0;
    for (int i = 0; i < n; i++)
      acc = acc + sum_t'(sa[i]) * sum_t'(sb[n-1-i]);
    return acc;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic word_t pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    if (r < 40) return word_t'($urandom_range(0, 15));
    return word_t'($urandom);
  endfunction

  // Offer one word, wait for the handshake, then update the predictor.
  task automatic send_pair(input word_t a, input word_t b, input logic fin,
                           input logic known, input sum_t typed);
    int   gap;
    sum_t predicted;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    a_value   <= a;
    b_value   <= b;
    last_pair <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pairs_sent++;
    // drop pairs beyond the store depth, final pair included
    if (held_a.size() < STORE_DEPTH) begin
      held_a.push_back(a);
      held_b.push_back(b);
    end
    if (fin) begin
      predicted = min_pairing_sum(held_a, held_b);
      pending_sums.push_back(known ? typed : predicted);
      held_a.delete();
      held_b.delete();
      lists_sent++;
    end
  endtask

  // Drain side: random stalls, plus one long hold-off to back the block up.
  initial begin : drain_side
    int  hold;
    bit  pressed;
    pressed = 1'b0;
    wait (!rst);
    forever begin
      hold = idle_len();
      if (!pressed && sums_taken >= 20) begin
        hold = 600;
        pressed = 1'b1;
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Compare each taken sum with the oldest one owed.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_sums.size() == 0)
        flag_mismatch($sformatf("unexpected sum %0d", min_sum));
      else if (min_sum !== pending_sums[0])
        flag_mismatch($sformatf("min_sum got %0d, want %0d", min_sum, pending_sums.pop_front()));
      else
        void'(pending_sums.pop_front());
      sums_taken++;
    end
  end

  initial begin : feed_side
    int len;
    int r;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int k = 0; k < $size(DIRECTED_ROWS); k++)
      send_pair(DIRECTED_ROWS[k].a, DIRECTED_ROWS[k].b, DIRECTED_ROWS[k].fin,
                DIRECTED_ROWS[k].known, DIRECTED_ROWS[k].sum);

    // overlong list at full scale: the largest possible sum
    for (int k = 0; k < STORE_DEPTH + 6; k++)
      send_pair('1, '1, k == STORE_DEPTH + 5, 1'b1, 38'd274869518400);
    overlong_lists++;
    // final pair lands on a full store and is lost
    for (int k = 0; k < STORE_DEPTH; k++)
      send_pair(16'd1, 16'd1, 1'b0, 1'b0, '0);
    send_pair('1, '1, 1'b1, 1'b1, 38'd64);
    overlong_lists++;
    // exactly full with random content
    for (int k = 0; k < STORE_DEPTH; k++)
      send_pair(pick_word(), pick_word(), k == STORE_DEPTH - 1, 1'b0, '0);

    // random lists, mostly short, a few past the store depth
    r = pairs_sent;
    while (pairs_sent - r < RANDOM_PAIRS) begin
      case ($urandom_range(0, 99)) inside
        [0:69]:  len = $urandom_range(1, 8);
        [70:91]: len = $urandom_range(9, 40);
        [92:96]: len = $urandom_range(41, STORE_DEPTH);
        default: len = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 8);
      endcase
      if (len > STORE_DEPTH) overlong_lists++;
      no_idle = (lists_sent >= 60 && lists_sent < 80);
      for (int k = 0; k < len; k++)
        send_pair(pick_word(), pick_word(), k == len - 1, 1'b0, '0);
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;

    while (pending_sums.size() != 0) @(posedge clk);
    repeat (STORE_DEPTH + 20) @(posedge clk);

    $display("Sent %0d pairs in %0d lists (%0d past the store depth); %0d sums taken.",
             pairs_sent, lists_sent, overlong_lists, sums_taken);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("Timed out with %0d sums outstanding", pending_sums.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
